// ===== design/crc_rd_pkg.sv =====
`default_nettype none
package crc_rd_pkg;

  localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;
  localparam logic [31:0] CRC_SEED_RESET  = 32'h0102_0304;
  localparam logic [30:0] MAX_LEN_RESET   = 31'h7FFF_FFFF;

  // configuration register indexes
  localparam logic CFG_CRC_SEED   = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_MISMATCH = 3'd2;
  localparam logic [2:0] KIND_BAD_LEN  = 3'd3;
  localparam logic [2:0] KIND_TRUNC    = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_PAY,
    PH_CRC,
    PH_DEAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic        last_payload;
    logic [30:0] length_seen;
  } res_t;

  // reflected CRC32C, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/crc_rd_core.sv =====
`default_nettype none
module crc_rd_core
  import crc_rd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire req_t        req,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             res_valid,
  output res_t             res
);

  logic [31:0] crc_seed;
  logic [30:0] max_length;

  phase_t      phase, phase_next;
  logic [30:0] position, position_next;
  logic [31:0] record_length, record_length_next;
  logic [31:0] crc_acc, crc_acc_next;
  logic        mismatch, mismatch_next;

  logic [31:0] len_acc;
  logic [31:0] len_byte;
  logic [30:0] pos_inc;
  logic [31:0] crc_upd;
  logic [31:0] crc_inv;
  logic [7:0]  expect_byte;
  logic        mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed   <= CRC_SEED_RESET;
      max_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRC_SEED:   crc_seed   <= cfg_data;
        CFG_MAX_LENGTH: max_length <= cfg_data[30:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (position[1:0])
      2'd0:    len_byte = {24'd0, req.data_byte};
      2'd1:    len_byte = {16'd0, req.data_byte, 8'd0};
      2'd2:    len_byte = {8'd0, req.data_byte, 16'd0};
      default: len_byte = {req.data_byte, 24'd0};
    endcase
    len_acc = ((position[1:0] == 2'd0) ? 32'd0 : record_length) | len_byte;

    crc_inv = ~crc_acc;
    unique case (position[1:0])
      2'd0:    expect_byte = crc_inv[7:0];
      2'd1:    expect_byte = crc_inv[15:8];
      2'd2:    expect_byte = crc_inv[23:16];
      default: expect_byte = crc_inv[31:24];
    endcase
    mm      = mismatch | (expect_byte != req.data_byte);
    pos_inc = position + 31'd1;
    crc_upd = crc_byte(crc_acc, req.data_byte);
  end

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    record_length_next = record_length;
    crc_acc_next       = crc_acc;
    mismatch_next      = mismatch;
    res_valid          = 1'b0;
    res                = '0;

    if (accept && (phase == PH_LEN || phase == PH_PAY || phase == PH_CRC)) begin
      if (req.req_type) begin
        res_valid = 1'b1;
        if (phase == PH_LEN && position[1:0] == 2'd0) begin
          phase_next = PH_DONE;
          res.kind   = KIND_END;
        end else begin
          // report whatever the length register holds, even a partial prefix
          phase_next      = PH_DEAD;
          res.kind        = KIND_TRUNC;
          res.length_seen = record_length[30:0];
        end
      end else begin
        unique case (phase)
          PH_LEN: begin
            record_length_next = len_acc;
            position_next      = pos_inc;
            if (position[1:0] == 2'd3) begin
              position_next = '0;
              if (len_acc[31] || len_acc[30:0] > max_length) begin
                phase_next      = PH_DEAD;
                res_valid       = 1'b1;
                res.kind        = KIND_BAD_LEN;
                res.length_seen = len_acc[30:0];
              end else begin
                crc_acc_next  = ~crc_seed;
                mismatch_next = 1'b0;
                phase_next    = (len_acc == 32'd0) ? PH_CRC : PH_PAY;
              end
            end
          end
          PH_PAY: begin
            crc_acc_next     = crc_upd;
            position_next    = pos_inc;
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload      = req.data_byte;
            if ({1'b0, pos_inc} == record_length) begin
              res.last_payload = 1'b1;
              phase_next       = PH_CRC;
              position_next    = '0;
            end
          end
          default: begin
            mismatch_next = mm;
            position_next = pos_inc;
            if (position[1:0] == 2'd3) begin
              position_next   = '0;
              res_valid       = 1'b1;
              res.length_seen = record_length[30:0];
              if (mm) begin
                phase_next = PH_DEAD;
                res.kind   = KIND_MISMATCH;
              end else begin
                phase_next = PH_LEN;
                res.kind   = KIND_GOOD;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      position      <= '0;
      record_length <= '0;
      crc_acc       <= '0;
      mismatch      <= 1'b0;
    end else begin
      phase         <= phase_next;
      position      <= position_next;
      record_length <= record_length_next;
      crc_acc       <= crc_acc_next;
      mismatch      <= mismatch_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/crc_rd_outq.sv =====
`default_nettype none
module crc_rd_outq
  import crc_rd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  res_t       head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_res   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case (count)
        2'd0: if (push) count <= 2'd1;
        2'd1: begin
          if (pop && !push) count <= 2'd0;
          else if (push && !pop) count <= 2'd2;
        end
        default: if (pop) count <= 2'd1;
      endcase
    end
  end

  // hold the head until taken; second slot absorbs one result while stalled
  always_ff @(posedge clk) begin
    unique case (count)
      2'd0: if (push) head <= push_data;
      2'd1: begin
        if (push && pop) head <= push_data;
        else if (push) tail <= push_data;
      end
      default: if (pop) head <= tail;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/crc_record_deframer.sv =====
// Each result is registered in the result queue's head slot and driven onto out_res.
// One request per cycle while in_ready is high; the byte-wide CRC32C step is combinational.
// A two-entry result queue keeps in_ready high while one result waits on out_ready.
// Reset (rst, synchronous): length phase, CRC seed 0x01020304, max length 0x7FFFFFFF,
// result queue empty.
`default_nettype none
module crc_record_deframer
  import crc_rd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire req_t        in_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic accept;
  logic res_valid;
  res_t res;
  logic full;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  crc_rd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  crc_rd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

// ===== tb/tb_crc_record_deframer.sv =====
`timescale 1ns / 1ps
module tb_crc_record_deframer;
  import crc_rd_pkg::*;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // how the stream ends; the block drops everything after it
  typedef enum int {
    END_CLEAN,
    END_IN_PREFIX,
    END_IN_PAYLOAD,
    END_IN_TRAILER,
    END_BAD_CRC,
    END_BAD_LEN
  } stream_end_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_res;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_CRC_SEED;
  logic [31:0] cfg_data = '0;

  logic        no_idle = 1'b0;
  logic        stall_go = 1'b0;
  logic        stall_done = 1'b0;
  int unsigned stall_left = 0;
  int          errors = 0;

  req_t        stream_q[$];
  res_t        deframed_q[$];
  logic [7:0]  record_bytes[$];

  // shadow copy of the deframer
  logic [31:0] seed_cfg = CRC_SEED_RESET;
  logic [30:0] maxlen_cfg = MAX_LEN_RESET;
  phase_t      ph = PH_LEN;
  logic [30:0] pos = '0;
  logic [31:0] rec_len = '0;
  logic [31:0] crc_reg = '0;
  logic        crc_bad = 1'b0;

  crc_record_deframer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // bit-serial CRC32C, LSB first
  function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic deframe_request(input req_t r);
    res_t        v;
    logic        last;
    logic [31:0] chk;
    v = '0;
    if (ph == PH_DEAD || ph == PH_DONE) return;
    if (r.req_type == REQ_EOS) begin
      if (ph == PH_LEN && pos == 0) begin
        ph = PH_DONE;
        v.kind = KIND_END;
      end else begin
        // the length field reports whatever the length register holds
        ph = PH_DEAD;
        v.kind = KIND_TRUNC;
        v.length_seen = rec_len[30:0];
      end
      deframed_q.push_back(v);
      return;
    end
    case (ph)
      PH_LEN: begin
        if (pos == 0) rec_len = '0;
        rec_len = rec_len | (32'(r.data_byte) << (8 * pos[1:0]));
        pos = pos + 31'd1;
        if (pos < 4) return;
        pos = '0;
        if (rec_len[31] || rec_len > {1'b0, maxlen_cfg}) begin
          ph = PH_DEAD;
          v.kind = KIND_BAD_LEN;
          v.length_seen = rec_len[30:0];
          deframed_q.push_back(v);
          return;
        end
        crc_reg = ~seed_cfg;
        crc_bad = 1'b0;
        ph = (rec_len == 0) ? PH_CRC : PH_PAY;
      end
      PH_PAY: begin
        crc_reg = crc32c_next(crc_reg, r.data_byte);
        pos = pos + 31'd1;
        last = ({1'b0, pos} == rec_len);
        if (last) begin
          ph = PH_CRC;
          pos = '0;
        end
        v.kind = KIND_PAYLOAD;
        v.payload = r.data_byte;
        v.last_payload = last;
        deframed_q.push_back(v);
      end
      default: begin
        chk = ~crc_reg;
        if (chk[8 * pos[1:0] +: 8] != r.data_byte) crc_bad = 1'b1;
        pos = pos + 31'd1;
        if (pos < 4) return;
        pos = '0;
        v.length_seen = rec_len[30:0];
        if (crc_bad) begin
          ph = PH_DEAD;
          v.kind = KIND_MISMATCH;
        end else begin
          ph = PH_LEN;
          v.kind = KIND_GOOD;
        end
        deframed_q.push_back(v);
      end
    endcase
  endtask

  function automatic void push_req(input logic eos, input logic [7:0] b);
    req_t r;
    r.req_type = eos;
    r.data_byte = b;
    stream_q.push_back(r);
  endfunction

  function automatic void push_span(input int lo, input int hi);
    for (int i = lo; i < hi; i++) push_req(REQ_BYTE, record_bytes[i]);
  endfunction

  // fill < 0 gives random payload bytes
  task automatic build_record(input int unsigned len, input bit corrupt, input int fill);
    logic [31:0] c;
    logic [7:0]  b;
    record_bytes.delete();
    for (int i = 0; i < 4; i++) record_bytes.push_back(len[8 * i +: 8]);
    c = ~seed_cfg;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      record_bytes.push_back(b);
      c = crc32c_next(c, b);
    end
    c = ~c;
    for (int i = 0; i < 4; i++) record_bytes.push_back(c[8 * i +: 8]);
    if (corrupt)
      record_bytes[len + 4 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
  endtask

  task automatic send_record(input int unsigned len, input bit corrupt, input int fill);
    build_record(len, corrupt, fill);
    push_span(0, record_bytes.size());
  endtask

  task automatic run_records(input int budget, input int unsigned cap);
    int          sent;
    int unsigned top;
    int unsigned len;
    sent = 0;
    top = (maxlen_cfg < cap) ? maxlen_cfg : cap;
    while (sent < budget) begin
      len = ($urandom_range(7) == 0) ? top : $urandom_range(top);
      send_record(len, 1'b0, -1);
      sent += len + 8;
    end
  endtask

  // hold until the stream is drained, plus the pipeline latency
  task automatic wait_idle();
    do @(posedge clk);
    while (stream_q.size() != 0 || in_valid || deframed_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_CRC_SEED) seed_cfg = value;
    else maxlen_cfg = value[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_request(in_req);
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
          in_req <= stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          errors++;
          if (errors <= 30)
            $display("%0t: unexpected result kind=%0d payload=%02h last=%0d len=%0d",
                     $time, out_res.kind, out_res.payload, out_res.last_payload,
                     out_res.length_seen);
        end else begin
          want = deframed_q.pop_front();
          if (out_res.kind !== want.kind || out_res.payload !== want.payload ||
              out_res.last_payload !== want.last_payload ||
              out_res.length_seen !== want.length_seen) begin
            errors++;
            if (errors <= 30)
              $display("%0t: expected kind=%0d payload=%02h last=%0d len=%0d, got kind=%0d payload=%02h last=%0d len=%0d",
                       $time, want.kind, want.payload, want.last_payload, want.length_seen,
                       out_res.kind, out_res.payload, out_res.last_payload,
                       out_res.length_seen);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (stall_go && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= 80;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    logic [31:0] bad;
    stream_end_t how;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty record, single-byte extremes, short runs
    send_record(0, 1'b0, -1);
    send_record(1, 1'b0, 8'h00);
    send_record(1, 1'b0, 8'hFF);
    send_record(3, 1'b0, 8'hFF);
    send_record(2, 1'b0, 8'h00);
    send_record(5, 1'b0, -1);
    wait_idle();

    // seed changes mid-payload, after the prefix: the trailer still uses the old one
    build_record(6, 1'b0, -1);
    push_span(0, 7);
    wait_idle();
    write_reg(CFG_CRC_SEED, $urandom);
    push_span(7, record_bytes.size());
    wait_idle();

    write_reg(CFG_CRC_SEED, 32'h0000_0000);
    write_reg(CFG_MAX_LENGTH, 32'd0);
    run_records(48, 0);
    wait_idle();

    write_reg(CFG_CRC_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_LENGTH, 32'd1);
    run_records(80, 1);
    wait_idle();

    write_reg(CFG_CRC_SEED, $urandom);
    write_reg(CFG_MAX_LENGTH, $urandom_range(20, 2));
    stall_go <= 1'b1;
    run_records(140, 20);
    wait_idle();

    write_reg(CFG_CRC_SEED, $urandom);
    write_reg(CFG_MAX_LENGTH, {1'b0, MAX_LEN_RESET});
    no_idle <= 1'b1;
    run_records(160, 24);
    wait_idle();
    no_idle <= 1'b0;

    write_reg(CFG_CRC_SEED, $urandom);
    write_reg(CFG_MAX_LENGTH, $urandom_range(40, 8));
    run_records(100, 40);

    how = stream_end_t'($urandom_range(5));
    len = $urandom_range(maxlen_cfg, 2);
    case (how)
      END_CLEAN: push_req(REQ_EOS, 8'($urandom_range(255)));
      END_IN_PREFIX: begin
        repeat ($urandom_range(3, 1)) push_req(REQ_BYTE, 8'($urandom_range(255)));
        push_req(REQ_EOS, 8'($urandom_range(255)));
      end
      END_IN_PAYLOAD: begin
        build_record(len, 1'b0, -1);
        push_span(0, 4 + $urandom_range(len - 1, 1));
        push_req(REQ_EOS, 8'($urandom_range(255)));
      end
      END_IN_TRAILER: begin
        build_record(len, 1'b0, -1);
        push_span(0, 4 + len + $urandom_range(3, 1));
        push_req(REQ_EOS, 8'($urandom_range(255)));
      end
      END_BAD_CRC: send_record(len, 1'b1, -1);
      default: begin
        bad = $urandom_range(1) ? {1'b1, 31'($urandom)}
                                : {1'b0, maxlen_cfg} + 32'd1 + $urandom_range(1000);
        for (int i = 0; i < 4; i++) push_req(REQ_BYTE, bad[8 * i +: 8]);
      end
    endcase
    // dropped after the stream has ended
    repeat (8) push_req(1'($urandom_range(1)), 8'($urandom_range(255)));

    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    n = 0;
    while (deframed_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (5) @(posedge clk);
    if (deframed_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
    end
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
